// ===== sv/rau_pkg.sv =====
// rau_pkg: shared widths, function codes and status codes of the rational
// arithmetic unit; no dependencies
package rau_pkg;

	localparam int unsigned WORD_BITS_DEF = 32;
	localparam int unsigned MAG_W = 65;

	typedef enum logic [3:0] {
		FN_MAKE = 4'd0,
		FN_ADD  = 4'd1,
		FN_SUB  = 4'd2,
		FN_MUL  = 4'd3,
		FN_DIV  = 4'd4,
		FN_GT   = 4'd5,
		FN_LT   = 4'd6,
		FN_GE   = 4'd7,
		FN_LE   = 4'd8,
		FN_EQ   = 4'd9,
		FN_NE   = 4'd10
	} func_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_ZDEN  = 2'd1,
		ST_OVFL  = 2'd2
	} status_t;

	typedef logic [MAG_W-1:0] mag_t;

endpackage

// ===== sv/rau_mul.sv =====
// rau_mul: 32 x 32 unsigned multiplier with a registered product
// depends on rau_pkg
module rau_mul (
	input  logic               clk,
	input  logic [31:0]        a,
	input  logic [31:0]        b,
	output rau_pkg::mag_t      p_q
);

	always_ff @(posedge clk) begin
		p_q <= rau_pkg::mag_t'({32'd0, a} * {32'd0, b});
	end

endmodule

// ===== sv/rau_div.sv =====
// rau_div: restoring divider, one quotient bit a cycle, shared by the gcd
// remainders and the final exact divisions; depends on rau_pkg
module rau_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  rau_pkg::mag_t      dividend,
	input  rau_pkg::mag_t      divisor,
	output logic               done,
	output rau_pkg::mag_t      quo_q,
	output rau_pkg::mag_t      rem_q
);

	localparam int unsigned CW = $clog2(rau_pkg::MAG_W + 1);

	logic [CW-1:0]      cnt_q;
	logic               busy_q;
	rau_pkg::mag_t      dsr_q;
	logic [rau_pkg::MAG_W:0] trial;

	assign trial = {rem_q, quo_q[rau_pkg::MAG_W-1]} - {1'b0, dsr_q};
	assign done  = busy_q && (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(rau_pkg::MAG_W);
		end else if (busy_q) begin
			if (cnt_q == '0) busy_q <= 1'b0;
			else cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q && cnt_q != '0) begin
			if (!trial[rau_pkg::MAG_W]) begin
				rem_q <= trial[rau_pkg::MAG_W-1:0];
				quo_q <= {quo_q[rau_pkg::MAG_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[rau_pkg::MAG_W-2:0], quo_q[rau_pkg::MAG_W-1]};
				quo_q <= {quo_q[rau_pkg::MAG_W-2:0], 1'b0};
			end
		end
	end

endmodule

// ===== sv/rational_arithmetic_unit_core.sv =====
// Rational arithmetic unit: takes two fractions and a function code and returns a
// reduced fraction, a comparison flag and a status. One item at a time: comparisons,
// errors and zero results go from the combine step straight to the output, and
// arithmetic runs a gcd on the shared bit-serial divider (up to about 90 remainder
// steps, depending on the operands) and then two exact divisions by the gcd. The
// result is held until out_ready. in_ready is high only when the block is empty.
// Depends on rau_pkg, rau_mul and rau_div.
module rational_arithmetic_unit_core #(
	parameter int unsigned WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [3:0]          func,
	input  logic signed [31:0]  a_num,
	input  logic signed [31:0]  a_den,
	input  logic signed [31:0]  b_num,
	input  logic [30:0]         b_den,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [31:0]  res_num,
	output logic [30:0]         res_den,
	output logic                cmp_true,
	output logic [1:0]          status
);

	typedef enum logic [10:0] {
		S_IDLE = 11'b00000000001,
		S_M1   = 11'b00000000010,
		S_M2   = 11'b00000000100,
		S_M3   = 11'b00000001000,
		S_COMB = 11'b00000010000,
		S_GCD  = 11'b00000100000,
		S_GWT  = 11'b00001000000,
		S_DN   = 11'b00010000000,
		S_DD   = 11'b00100000000,
		S_FIN  = 11'b01000000000,
		S_OUT  = 11'b10000000000
	} state_t;

	state_t             st_q;
	logic [3:0]         fn_q;
	logic               an_neg_q, ad_neg_q, bn_neg_q;
	logic [31:0]        an_q, ad_q, bn_q, bd_q;
	rau_pkg::mag_t      p1_q, p2_q, num_q, den_q, gx_q, gy_q, g_q, qn_q;
	logic               num_neg_q, neg_q;
	logic [31:0]        ma, mb;
	rau_pkg::mag_t      prod;
	logic               dv_start, dv_done;
	rau_pkg::mag_t      dv_a, dv_b, dv_quo, dv_rem;
	logic               n1, n2;
	logic               sneg;
	rau_pkg::mag_t      smag;
	logic               lt_v, eq_v;
	logic               zden, go_gcd;
	logic               dv_kick_q;

	localparam rau_pkg::mag_t LIM = rau_pkg::mag_t'(1) << (WORD_BITS - 1);

	rau_mul u_mul (.clk(clk), .a(ma), .b(mb), .p_q(prod));
	rau_div u_div (.clk(clk), .arst_n(arst_n), .start(dv_start), .dividend(dv_a),
		.divisor(dv_b), .done(dv_done), .quo_q(dv_quo), .rem_q(dv_rem));

	assign in_ready  = (st_q == S_IDLE);
	assign out_valid = (st_q == S_OUT);

	always_comb begin
		ma = an_q;
		mb = bd_q;
		unique case (st_q)
			S_M1: begin
				if (fn_q == rau_pkg::FN_MUL) mb = bn_q;
			end
			S_M2: begin
				ma = bn_q; mb = ad_q;
				if (fn_q == rau_pkg::FN_MUL) begin ma = ad_q; mb = bd_q; end
				if (fn_q == rau_pkg::FN_DIV) begin ma = ad_q; mb = bn_q; end
			end
			default: begin
				ma = ad_q; mb = bd_q;
			end
		endcase
	end

	// signs of the two products for add/sub/compare
	assign n1 = an_neg_q && (p1_q != '0);
	assign n2 = (bn_neg_q != ad_neg_q) && (p2_q != '0);
	always_comb begin
		logic nb;
		nb = (fn_q == rau_pkg::FN_ADD) ? n2 : !n2;
		if (n1 == nb) begin
			smag = p1_q + p2_q;
			sneg = n1;
		end else if (p1_q >= p2_q) begin
			smag = p1_q - p2_q;
			sneg = n1;
		end else begin
			smag = p2_q - p1_q;
			sneg = nb;
		end
		if (smag == '0) sneg = 1'b0;
	end
	assign eq_v = (smag == '0);
	assign lt_v = !eq_v && (sneg != ad_neg_q);

	assign zden = (ad_q == '0) || (fn_q != rau_pkg::FN_MAKE && bd_q == '0)
		|| (fn_q == rau_pkg::FN_DIV && bn_q == '0);
	assign go_gcd = (fn_q <= 4'(rau_pkg::FN_DIV)) && !zden
		&& ((fn_q == rau_pkg::FN_ADD || fn_q == rau_pkg::FN_SUB) ? (smag != '0)
			: (num_q != '0));

	assign dv_start = (st_q == S_GCD && gy_q != '0)
		|| ((st_q == S_DN || st_q == S_DD) && dv_kick_q);
	always_comb begin
		dv_a = gx_q;
		dv_b = gy_q;
		if (st_q == S_DN) begin dv_a = num_q; dv_b = g_q; end
		if (st_q == S_DD) begin dv_a = den_q; dv_b = g_q; end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_IDLE;
			dv_kick_q <= 1'b0;
		end else begin
			unique case (st_q)
				S_IDLE: if (in_valid) st_q <= S_M1;
				S_M1:   st_q <= S_M2;
				S_M2:   st_q <= S_M3;
				S_M3:   st_q <= S_COMB;
				S_COMB: st_q <= go_gcd ? S_GCD : S_OUT;
				S_GCD:  st_q <= (gy_q == '0) ? S_DN : S_GWT;
				S_GWT:  if (dv_done) st_q <= S_GCD;
				S_DN:   if (!dv_kick_q && dv_done) st_q <= S_DD;
				S_DD:   if (!dv_kick_q && dv_done) st_q <= S_FIN;
				S_FIN:  st_q <= S_OUT;
				S_OUT:  if (out_ready) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
			dv_kick_q <= (st_q == S_GCD && gy_q == '0)
				|| (st_q == S_DN && !dv_kick_q && dv_done);
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			S_IDLE: begin
				fn_q     <= func;
				an_neg_q <= a_num[31];
				ad_neg_q <= a_den[31];
				bn_neg_q <= b_num[31];
				an_q     <= a_num[31] ? 32'(-a_num) : a_num;
				ad_q     <= a_den[31] ? 32'(-a_den) : a_den;
				bn_q     <= b_num[31] ? 32'(-b_num) : b_num;
				bd_q     <= {1'b0, b_den};
				res_num  <= '0;
				res_den  <= 31'd1;
				cmp_true <= 1'b0;
				status   <= rau_pkg::ST_OK;
			end
			S_M2: p1_q <= prod;
			S_M3: begin
				p2_q <= prod;
				if (fn_q == rau_pkg::FN_MUL || fn_q == rau_pkg::FN_DIV)
					den_q <= prod;
				else if (fn_q == rau_pkg::FN_MAKE)
					den_q <= rau_pkg::mag_t'(ad_q);
				else begin
					den_q <= '0;
				end
			end
			S_COMB: begin
				if (fn_q > 4'(rau_pkg::FN_NE)) begin
					status <= rau_pkg::ST_OK;
				end else if (zden) begin
					status <= rau_pkg::ST_ZDEN;
				end else if (fn_q >= 4'(rau_pkg::FN_GT)) begin
					unique case (fn_q)
						rau_pkg::FN_GT: cmp_true <= !lt_v && !eq_v;
						rau_pkg::FN_LT: cmp_true <= lt_v;
						rau_pkg::FN_GE: cmp_true <= !lt_v;
						rau_pkg::FN_LE: cmp_true <= lt_v || eq_v;
						rau_pkg::FN_EQ: cmp_true <= eq_v;
						default:        cmp_true <= !eq_v;
					endcase
				end
			end
			S_GCD: g_q <= gx_q;
			S_GWT: if (dv_done) begin gx_q <= gy_q; gy_q <= dv_rem; end
			S_DN:  if (!dv_kick_q && dv_done) qn_q <= dv_quo;
			S_FIN: begin
				if (dv_quo > LIM - 1 || qn_q > (neg_q ? LIM : LIM - 1))
					status <= rau_pkg::ST_OVFL;
				else begin
					res_num <= neg_q ? 32'(-qn_q[31:0]) : qn_q[31:0];
					res_den <= dv_quo[30:0];
				end
			end
			default: ;
		endcase
		if (st_q == S_M3) begin
			unique case (fn_q)
				rau_pkg::FN_MAKE: begin
					num_q <= rau_pkg::mag_t'(an_q); num_neg_q <= an_neg_q;
				end
				rau_pkg::FN_MUL: begin
					num_q <= p1_q; num_neg_q <= (an_neg_q != bn_neg_q);
				end
				rau_pkg::FN_DIV: begin
					num_q <= p1_q; num_neg_q <= an_neg_q != bn_neg_q;
				end
				default: ;
			endcase
		end
		if (st_q == S_COMB) begin
			if (fn_q == rau_pkg::FN_ADD || fn_q == rau_pkg::FN_SUB) begin
				num_q <= smag; num_neg_q <= sneg;
				gx_q  <= smag;
				den_q <= prod;
				gy_q  <= prod;
			end else begin
				gx_q <= num_q;
				gy_q <= (fn_q == rau_pkg::FN_MAKE) ? rau_pkg::mag_t'(ad_q) : den_q;
			end
			neg_q <= ((fn_q == rau_pkg::FN_ADD || fn_q == rau_pkg::FN_SUB) ? sneg : num_neg_q)
				!= ad_neg_q;
		end
	end

endmodule
